// File: hw/rtl/dts_core_header_finder_assert.svh
// Assertion macros shared by the header finder modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DTS_CORE_HEADER_FINDER_ASSERT_SVH
`define DTS_CORE_HEADER_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTSHF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTSHF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dtshf_pkg.sv
`timescale 1ns / 1ps

package dtshf_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_HEADER = 3'd1,
        ST_BAD_SIZE  = 3'd2,
        ST_BAD_RATE  = 3'd3,
        ST_BAD_REV   = 3'd4,
        ST_BAD_RES   = 3'd5
    } status_t;

    // Per-buffer parse phase.
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    localparam int unsigned HDR_BYTES = 12;
    localparam int unsigned HDR_BITS  = HDR_BYTES * 8;

    localparam logic [23:0] SYNC_HEAD = 24'h7FFE80;
    localparam logic [7:0]  SYNC_TAIL = 8'h01;
    localparam logic [15:0] POS_SAT   = 16'hFFFF;

    localparam logic [13:0] MIN_FRAME_RAW  = 14'd95;
    localparam logic [6:0]  FEW_BLOCKS_RAW = 7'd5;
    localparam logic [3:0]  MAX_REV        = 4'd7;
    localparam logic [3:0]  REV_GAIN_REL   = 4'd7;
    localparam logic [3:0]  REV_GAIN_ABS   = 4'd6;
    localparam logic [5:0]  GAIN_BIAS_REV6 = 6'd48;   // -16 in six bits

    // Header word handed from the scanner to the decoder.
    typedef struct packed {
        logic                no_header;
        logic [15:0]         sync_pos;
        logic [HDR_BITS-1:0] window;
    } evt_t;

    // Decoded result fields.
    typedef struct packed {
        status_t     status;
        logic [15:0] sync_offset;
        logic [14:0] frame_bytes;
        logic [7:0]  sample_blocks;
        logic [4:0]  channel_count;
        logic [5:0]  arrangement_code;
        logic [15:0] sample_rate;
        logic [22:0] bit_rate;
        logic [4:0]  pcm_bits;
        logic [5:0]  dialog_gain;
        logic [15:0] coding_fields;
        logic [14:0] flag_bits;
    } res_t;

    // Channel count for arrangement codes 0 to 15.
    function automatic logic [4:0] chan_of(input logic [3:0] code);
        logic [4:0] c;
        unique case (code)
            4'd0:                      c = 5'd1;
            4'd1, 4'd2, 4'd3, 4'd4:    c = 5'd2;
            4'd5, 4'd6:                c = 5'd3;
            4'd7, 4'd8:                c = 5'd4;
            4'd9:                      c = 5'd5;
            4'd10, 4'd11, 4'd12:       c = 5'd6;
            4'd13:                     c = 5'd7;
            default:                   c = 5'd8;
        endcase
        return c;
    endfunction

    // Core sample rate in Hz; zero marks a reserved code.
    function automatic logic [15:0] rate_of(input logic [3:0] code);
        logic [15:0] r;
        unique case (code)
            4'd1:    r = 16'd8000;
            4'd2:    r = 16'd16000;
            4'd3:    r = 16'd32000;
            4'd6:    r = 16'd11025;
            4'd7:    r = 16'd22050;
            4'd8:    r = 16'd44100;
            4'd11:   r = 16'd12000;
            4'd12:   r = 16'd24000;
            4'd13:   r = 16'd48000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // Transmission bit rate; the top three codes are open, variable, lossless.
    function automatic logic [22:0] brate_of(input logic [4:0] code);
        logic [22:0] r;
        unique case (code)
            5'd0:    r = 23'd32000;
            5'd1:    r = 23'd56000;
            5'd2:    r = 23'd64000;
            5'd3:    r = 23'd96000;
            5'd4:    r = 23'd112000;
            5'd5:    r = 23'd128000;
            5'd6:    r = 23'd192000;
            5'd7:    r = 23'd224000;
            5'd8:    r = 23'd256000;
            5'd9:    r = 23'd320000;
            5'd10:   r = 23'd384000;
            5'd11:   r = 23'd448000;
            5'd12:   r = 23'd512000;
            5'd13:   r = 23'd576000;
            5'd14:   r = 23'd640000;
            5'd15:   r = 23'd768000;
            5'd16:   r = 23'd960000;
            5'd17:   r = 23'd1024000;
            5'd18:   r = 23'd1152000;
            5'd19:   r = 23'd1280000;
            5'd20:   r = 23'd1344000;
            5'd21:   r = 23'd1408000;
            5'd22:   r = 23'd1411200;
            5'd23:   r = 23'd1472000;
            5'd24:   r = 23'd1536000;
            5'd25:   r = 23'd1920000;
            5'd26:   r = 23'd2048000;
            5'd27:   r = 23'd3072000;
            5'd28:   r = 23'd3840000;
            5'd29:   r = 23'h7FFFFF;
            5'd30:   r = 23'h7FFFFE;
            default: r = 23'h7FFFFD;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/dtshf_scan.sv
`timescale 1ns / 1ps

module dtshf_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_data,
    input  logic                 in_last,
    input  logic                 evt_take,
    output logic                 evt_valid,
    output dtshf_pkg::evt_t      evt
);
    import dtshf_pkg::*;

    `include "dts_core_header_finder_assert.svh"

    phase_t              phase_reg, phase_next;
    logic [23:0]         win_reg, win_next;
    logic [1:0]          lead_reg, lead_next;
    logic [15:0]         pos_reg, pos_next;
    logic [15:0]         sync_pos_reg, sync_pos_next;
    logic [HDR_BITS-1:0] hdr_reg, hdr_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                evt_valid_reg, evt_valid_next;
    logic                nohdr_reg, nohdr_next;
    logic                accept;
    logic                emit;

    // A new byte is taken whenever the event register is empty or drains now.
    assign in_ready = !evt_valid_reg || evt_take;
    assign accept   = in_valid && in_ready;

    // Sync hunt, header collection and per-buffer restart.
    always_comb
    begin
        phase_next     = phase_reg;
        win_next       = win_reg;
        lead_next      = lead_reg;
        pos_next       = pos_reg;
        sync_pos_next  = sync_pos_reg;
        hdr_next       = hdr_reg;
        cnt_next       = cnt_reg;
        nohdr_next     = nohdr_reg;
        emit           = 1'b0;
        evt_valid_next = evt_take ? 1'b0 : evt_valid_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (lead_reg == 2'd3 && win_reg == SYNC_HEAD && in_data == SYNC_TAIL)
                    begin
                        sync_pos_next = pos_reg;
                        phase_next    = PH_COLLECT;
                        cnt_next      = 4'd0;
                    end
                    win_next = {win_reg[15:0], in_data};
                end
                PH_COLLECT:
                begin
                    hdr_next = {hdr_reg[HDR_BITS-9:0], in_data};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'(HDR_BYTES - 1))
                    begin
                        emit       = 1'b1;
                        nohdr_next = 1'b0;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase

            // Offset of the oldest byte in the sync window, saturating.
            if (lead_reg != 2'd3)
                lead_next = lead_reg + 2'd1;
            else if (pos_reg != POS_SAT)
                pos_next = pos_reg + 16'd1;

            // The last word closes the buffer, reporting a miss if nothing was sent.
            if (in_last)
            begin
                if (!emit && phase_reg != PH_DONE)
                begin
                    emit       = 1'b1;
                    nohdr_next = 1'b1;
                end
                phase_next = PH_HUNT;
                win_next   = 24'd0;
                pos_next   = 16'd0;
                lead_next  = 2'd0;
                cnt_next   = 4'd0;
            end

            if (emit)
                evt_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            win_reg       <= 24'd0;
            lead_reg      <= 2'd0;
            pos_reg       <= 16'd0;
            cnt_reg       <= 4'd0;
            evt_valid_reg <= 1'b0;
            nohdr_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            win_reg       <= win_next;
            lead_reg      <= lead_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            evt_valid_reg <= evt_valid_next;
            nohdr_reg     <= nohdr_next;
        end
    end

    // Header bytes and sync offset.
    always_ff @(posedge clk)
    begin
        sync_pos_reg <= sync_pos_next;
        hdr_reg      <= hdr_next;
    end

    assign evt_valid     = evt_valid_reg;
    assign evt.no_header = nohdr_reg;
    assign evt.sync_pos  = sync_pos_reg;
    assign evt.window    = hdr_reg;

    `DTSHF_ASSERT_SAME(a_lead_full, phase_reg != PH_HUNT, lead_reg == 2'd3,
        "sync found before three words were seen")
    `DTSHF_ASSERT_SAME(a_cnt_range, phase_reg == PH_COLLECT, cnt_reg < 4'(HDR_BYTES),
        "header count ran past the window")
    `DTSHF_ASSERT_NEXT(a_hdr_hold, evt_valid_reg && !evt_take,
        evt_valid_reg && $stable(hdr_reg), "header changed while its event waited")

endmodule

// File: hw/rtl/dtshf_decode.sv
`timescale 1ns / 1ps

module dtshf_decode (
    input  dtshf_pkg::evt_t  evt,
    output dtshf_pkg::res_t  res
);
    import dtshf_pkg::*;

    logic [HDR_BITS-1:0] w;
    logic                normal, crc, extc, subs, pred;
    logic [4:0]          deficit_raw, rate_code, five;
    logic [6:0]          nblks;
    logic [13:0]         fsize;
    logic [5:0]          amode;
    logic [3:0]          sfreq;
    logic [2:0]          ext;
    logic [1:0]          lfe;
    logic [15:0]         tail;
    logic                interp, fdiff, sdiff;
    logic [3:0]          rev, dn;
    logic [1:0]          copy;
    logic [2:0]          pcmr;
    logic [4:0]          bits;
    logic                es, res_ok;
    logic [15:0]         rate_hz;
    logic [5:0]          gain;
    status_t             status;

    // Fixed header fields, most significant bit first.
    assign w           = evt.window;
    assign normal      = w[95];
    assign deficit_raw = w[94:90];
    assign crc         = w[89];
    assign nblks       = w[88:82];
    assign fsize       = w[81:68];
    assign amode       = w[67:62];
    assign sfreq       = w[61:58];
    assign rate_code   = w[57:53];
    assign five        = w[52:48];
    assign ext         = w[47:45];
    assign extc        = w[44];
    assign subs        = w[43];
    assign lfe         = w[42:41];
    assign pred        = w[40];

    // The remaining fields sit two bytes later when the CRC word is present.
    assign tail   = crc ? w[23:8] : w[39:24];
    assign interp = tail[15];
    assign rev    = tail[14:11];
    assign copy   = tail[10:9];
    assign pcmr   = tail[8:6];
    assign fdiff  = tail[5];
    assign sdiff  = tail[4];
    assign dn     = tail[3:0];

    assign rate_hz = rate_of(sfreq);

    // PCM resolution and the ES flag folded into its code.
    always_comb
    begin
        bits   = 5'd16;
        es     = 1'b0;
        res_ok = 1'b1;
        unique case (pcmr)
            3'd0:    begin bits = 5'd16; es = 1'b0; end
            3'd1:    begin bits = 5'd16; es = 1'b1; end
            3'd2:    begin bits = 5'd20; es = 1'b0; end
            3'd3:    begin bits = 5'd20; es = 1'b1; end
            3'd5:    begin bits = 5'd24; es = 1'b1; end
            3'd6:    begin bits = 5'd24; es = 1'b0; end
            default: res_ok = 1'b0;
        endcase
    end

    // Dialog gain depends on the encoder revision.
    always_comb
    begin
        if (rev == REV_GAIN_REL)
            gain = 6'd0 - {2'b00, dn};
        else if (rev == REV_GAIN_ABS)
            gain = GAIN_BIAS_REV6 - {2'b00, dn};
        else
            gain = 6'd0;
    end

    // Checks in fixed order.
    always_comb
    begin
        priority if (evt.no_header)
            status = ST_NO_HEADER;
        else if (fsize < MIN_FRAME_RAW)
            status = ST_BAD_SIZE;
        else if (rate_hz == 16'd0)
            status = ST_BAD_RATE;
        else if (rev > MAX_REV)
            status = ST_BAD_REV;
        else if (!res_ok)
            status = ST_BAD_RES;
        else
            status = ST_OK;
    end

    // Any failure zeroes every field but the status.
    always_comb
    begin
        res        = '0;
        res.status = status;
        if (status == ST_OK)
        begin
            res.sync_offset      = evt.sync_pos;
            res.frame_bytes      = {1'b0, fsize} + 15'd1;
            res.sample_blocks    = {1'b0, nblks} + 8'd1;
            res.channel_count    = (amode[5:4] == 2'b00) ? chan_of(amode[3:0]) : 5'h1F;
            res.arrangement_code = amode;
            res.sample_rate      = rate_hz;
            res.bit_rate         = brate_of(rate_code);
            res.pcm_bits         = bits;
            res.dialog_gain      = gain;
            res.coding_fields    = {deficit_raw + 5'd1, ext, lfe, rev, copy};
            res.flag_bits        = {normal, crc, five, extc, subs, pred, interp,
                                    fdiff, sdiff, es, (nblks < FEW_BLOCKS_RAW)};
        end
    end

endmodule

// File: hw/rtl/dts_core_header_finder.sv
`timescale 1ns / 1ps

// Finds the first core frame header in each buffer of bytes and reports it as one
// result word per buffer. Bytes arrive one per word on the slave side, tlast on the
// buffer's final byte. A byte is taken every clock cycle while s_tready is high;
// s_tready only drops while a finished result waits in the output register and a
// second one is already held behind it. Once the byte that completes the 12-byte
// header window is taken (or the buffer's last byte when no header was found), the
// result is held in the scanner's event register, then after decode in the output register.
// On any error status all other result fields are zero; sync_offset saturates.
module dts_core_header_finder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tlast,   // last_byte
    output logic          m_tvalid,
    input  logic          m_tready,
    // [2:0] status, [18:3] sync_offset, [33:19] frame_bytes, [41:34] sample_blocks,
    // [46:42] channel_count, [52:47] arrangement_code, [68:53] sample_rate,
    // [91:69] bit_rate, [96:92] pcm_bits, [102:97] dialog_gain,
    // [118:103] coding_fields, [133:119] flag_bits, [135:134] zero
    output logic [135:0]  m_tdata
);
    import dtshf_pkg::*;

    `include "dts_core_header_finder_assert.svh"

    logic           out_free;
    logic           evt_valid;
    logic           evt_take;
    evt_t           evt;
    res_t           res;
    logic           m_valid_reg, m_valid_next;
    logic [135:0]   m_data_reg, m_data_next;

    // The output register frees when empty or when its word is taken now.
    assign out_free = !m_valid_reg || m_tready;
    assign evt_take = evt_valid && out_free;

    dtshf_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .evt_take  (evt_take),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    dtshf_decode u_decode (
        .evt (evt),
        .res (res)
    );

    // Output register load.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free)
        begin
            m_valid_next = evt_valid;
            m_data_next  = {2'b00, res.flag_bits, res.coding_fields, res.dialog_gain,
                            res.pcm_bits, res.bit_rate, res.sample_rate,
                            res.arrangement_code, res.channel_count, res.sample_blocks,
                            res.frame_bytes, res.sync_offset, res.status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `DTSHF_ASSERT_SAME(a_err_zero, m_tvalid && m_tdata[2:0] != ST_OK,
        m_tdata[135:3] == '0, "error result carries nonzero fields")
    `DTSHF_ASSERT_SAME(a_ok_pcm, m_tvalid && m_tdata[2:0] == ST_OK,
        m_tdata[96:92] == 5'd16 || m_tdata[96:92] == 5'd20 || m_tdata[96:92] == 5'd24,
        "ok result with bad PCM resolution")
    `DTSHF_ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid && !m_tready,
        "input stalled without a blocked output")

endmodule
